// File: rtl/qpr_pkg.sv
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared types, widths and the Hamilton product sign table for the
// quaternion point rotation pipeline.
// ----------------------------------------------------------------------------
package qpr_pkg;

  localparam int VAL_W         = 18;
  localparam int PROD_W        = 2 * VAL_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 2;

  typedef logic signed [VAL_W-1:0]  val_t;
  typedef val_t                     quat_t [4];
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef prod_t                    prod_mat_t [4][4];

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_W = CFG_IDX_W'(0),
    REG_ROT_X = CFG_IDX_W'(1),
    REG_ROT_Y = CFG_IDX_W'(2),
    REG_ROT_Z = CFG_IDX_W'(3)
  } reg_idx_t;

  // output k of a*b sums a[i]*b[i^k]; bit i set means that term is subtracted
  localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

endpackage

// File: rtl/qpr_mult.sv
// ----------------------------------------------------------------------------
// qpr_mult
// Registered 4x4 array of 18x18 signed products of two quaternions.
// ----------------------------------------------------------------------------
module qpr_mult (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  qpr_pkg::quat_t    a,
  input  qpr_pkg::quat_t    b,
  output logic              out_valid,
  output qpr_pkg::prod_mat_t prod
);
  import qpr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod[i][j] <= PROD_W'(a[i]) * PROD_W'(b[j]);
      end
    end
  end

endmodule

// File: rtl/qpr_sum.sv
// ----------------------------------------------------------------------------
// qpr_sum
// Hamilton product sums over registered products, rounded to nearest and
// saturated to the 18-bit range, then registered.
// ----------------------------------------------------------------------------
module qpr_sum #(
  parameter int FRAC_BITS = qpr_pkg::FRAC_BITS_DEF,
  parameter bit CONJ_B    = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  qpr_pkg::prod_mat_t prod,
  output logic               out_valid,
  output qpr_pkg::quat_t     res
);
  import qpr_pkg::*;

  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (VAL_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  logic signed [SUM_W-1:0] acc [4];
  logic signed [SUM_W-1:0] sh  [4];
  quat_t                   res_next;

  always_comb begin
    logic signed [SUM_W-1:0] term;
    logic                    neg;
    for (int k = 0; k < 4; k++) begin
      acc[k] = HALF;
      for (int i = 0; i < 4; i++) begin
        term = SUM_W'(prod[i][i ^ k]);
        neg  = HAM_NEG[k][i] ^ (CONJ_B && (i != k));
        acc[k] = neg ? (acc[k] - term) : (acc[k] + term);
      end
      sh[k] = acc[k] >>> FRAC_BITS;
      if (sh[k] > SAT_HI) begin
        res_next[k] = SAT_HI[VAL_W-1:0];
      end else if (sh[k] < SAT_LO) begin
        res_next[k] = SAT_LO[VAL_W-1:0];
      end else begin
        res_next[k] = sh[k][VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

// File: rtl/quaternion_point_rotation.sv
// ----------------------------------------------------------------------------
// quaternion_point_rotation
// Rotates points by the configured quaternion: t = p * conj(q), r = q * t.
// Pipelined, with one registered stage per multiply and per
// round-and-saturate sum. Throughput: one item every cycle; busy
// stays low and results cannot be held off. Reset clears the valid chain
// and loads the identity rotation.
// ----------------------------------------------------------------------------
module quaternion_point_rotation #(
  parameter int FRAC_BITS = qpr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [qpr_pkg::VAL_W-1:0] point_x,
  input  logic signed [qpr_pkg::VAL_W-1:0] point_y,
  input  logic signed [qpr_pkg::VAL_W-1:0] point_z,
  output logic                            done,
  output logic signed [qpr_pkg::VAL_W-1:0] out_w,
  output logic signed [qpr_pkg::VAL_W-1:0] out_x,
  output logic signed [qpr_pkg::VAL_W-1:0] out_y,
  output logic signed [qpr_pkg::VAL_W-1:0] out_z,
  input  logic                            cfg_we,
  input  logic [qpr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic signed [qpr_pkg::VAL_W-1:0] cfg_data
);
  import qpr_pkg::*;

  localparam longint ONE_FIX   = longint'(1) << FRAC_BITS;
  localparam longint VMAX      = (longint'(1) << (VAL_W - 1)) - 1;
  localparam val_t   ROT_W_RST = VAL_W'((ONE_FIX > VMAX) ? VMAX : ONE_FIX);

  quat_t     rot;
  quat_t     pnt;
  quat_t     t_q;
  quat_t     r_q;
  prod_mat_t prod1;
  prod_mat_t prod2;
  logic      v1;
  logic      v2;
  logic      v3;
  logic      accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[0] <= ROT_W_RST;
      rot[1] <= '0;
      rot[2] <= '0;
      rot[3] <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ROT_W: rot[0] <= cfg_data;
        REG_ROT_X: rot[1] <= cfg_data;
        REG_ROT_Y: rot[2] <= cfg_data;
        REG_ROT_Z: rot[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pnt[0] = '0;
  assign pnt[1] = point_x;
  assign pnt[2] = point_y;
  assign pnt[3] = point_z;

  // t = p * conj(q)
  qpr_mult u_mult1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .a         (pnt),
    .b         (rot),
    .out_valid (v1),
    .prod      (prod1)
  );

  qpr_sum #(
    .FRAC_BITS (FRAC_BITS),
    .CONJ_B    (1'b1)
  ) u_sum1 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .prod      (prod1),
    .out_valid (v2),
    .res       (t_q)
  );

  // r = q * t
  qpr_mult u_mult2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .a         (rot),
    .b         (t_q),
    .out_valid (v3),
    .prod      (prod2)
  );

  qpr_sum #(
    .FRAC_BITS (FRAC_BITS),
    .CONJ_B    (1'b0)
  ) u_sum2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .prod      (prod2),
    .out_valid (done),
    .res       (r_q)
  );

  assign out_w = r_q[0];
  assign out_x = r_q[1];
  assign out_y = r_q[2];
  assign out_z = r_q[3];

endmodule

// File: rtl/qpr_checker.sv
// ----------------------------------------------------------------------------
// qpr_checker
// Port-level checks on the rotation pipeline timing, bound to the top level.
// ----------------------------------------------------------------------------
module qpr_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // pipeline never pushes back
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // every accepted item comes out as a done strobe
  a_item_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("item lost in pipeline");

  // no result without an earlier accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without item");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("done after reset");

endmodule

bind quaternion_point_rotation qpr_checker u_qpr_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quaternion_point_rotation. Points are sent through
// the start handshake, and every accepted item gets its expected rotated
// quaternion from a fixed-point predictor. Each done strobe is checked field
// by field against the oldest expectation. The rotation registers are changed
// only while the pipeline is empty. The run starts with identity, extreme and
// non-unit rotations, then random phases with unit, extreme and fully random
// quaternions. Gaps are random except in each fourth and the closing phases.
// ----------------------------------------------------------------------------
module testbench;
  import qpr_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint VAL_MAX = (longint'(1) <<< (VAL_W - 1)) - 1;
  localparam longint VAL_MIN = -(longint'(1) <<< (VAL_W - 1));
  localparam int ITEMS_PER_PHASE = 100;
  localparam int RANDOM_PHASES = 10;
  localparam int QUIET_PHASES = 2;

  typedef struct {
    val_t w;
    val_t x;
    val_t y;
    val_t z;
  } rot_result_t;

  class rotation_scoreboard;
    longint qw, qx, qy, qz;
    rot_result_t pending_rot[$];
    int unsigned mismatches;

    function new();
      qw = longint'(1) <<< FRAC;
      if (qw > VAL_MAX) qw = VAL_MAX;
      qx = 0;
      qy = 0;
      qz = 0;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_t idx, val_t v);
      case (idx)
        REG_ROT_W: qw = longint'(v);
        REG_ROT_X: qx = longint'(v);
        REG_ROT_Y: qy = longint'(v);
        REG_ROT_Z: qz = longint'(v);
        default: ;
      endcase
    endfunction

    function longint round_sat(longint s);
      longint r;
      r = (s + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      if (r > VAL_MAX) r = VAL_MAX;
      if (r < VAL_MIN) r = VAL_MIN;
      return r;
    endfunction

    // t = p * conj(q), then r = q * t
    function void note_point(val_t x, val_t y, val_t z);
      longint px, py, pz, tw, tx, ty, tz;
      rot_result_t r;
      px = longint'(x);
      py = longint'(y);
      pz = longint'(z);
      tw = round_sat(px * qx + py * qy + pz * qz);
      tx = round_sat(px * qw - py * qz + pz * qy);
      ty = round_sat(px * qz + py * qw - pz * qx);
      tz = round_sat(-px * qy + py * qx + pz * qw);
      r.w = val_t'(round_sat(qw * tw - qx * tx - qy * ty - qz * tz));
      r.x = val_t'(round_sat(qw * tx + qx * tw + qy * tz - qz * ty));
      r.y = val_t'(round_sat(qw * ty - qx * tz + qy * tw + qz * tx));
      r.z = val_t'(round_sat(qw * tz + qx * ty - qy * tx + qz * tw));
      pending_rot.push_back(r);
    endfunction

    function void check_field(string name, val_t want, val_t got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: out_%s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(val_t w, val_t x, val_t y, val_t z);
      rot_result_t e;
      if (pending_rot.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d", $time, w, x, y, z);
        return;
      end
      e = pending_rot.pop_front();
      check_field("w", e.w, w);
      check_field("x", e.x, x);
      check_field("y", e.y, y);
      check_field("z", e.z, z);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  val_t point_x = '0;
  val_t point_y = '0;
  val_t point_z = '0;
  logic done;
  val_t out_w;
  val_t out_x;
  val_t out_y;
  val_t out_z;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  val_t cfg_data = '0;

  rotation_scoreboard sb;

  quaternion_point_rotation DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .done(done),
    .out_w(out_w),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(out_w, out_x, out_y, out_z);
  end

  task automatic send_point(val_t x, val_t y, val_t z, bit may_idle);
    start <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_point(x, y, z);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_rot.size() != 0) @(posedge clk);
  endtask

  task automatic set_rotation(val_t w, val_t x, val_t y, val_t z);
    val_t vals[4];
    vals[0] = w;
    vals[1] = x;
    vals[2] = y;
    vals[3] = z;
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(reg_idx_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic val_t pick_coord();
    case ($urandom_range(0, 9))
      0: return val_t'(VAL_MAX);
      1: return val_t'(VAL_MIN);
      2: return val_t'(int'($urandom_range(0, 4)) - 2);
      3, 4, 5: return val_t'(int'($urandom_range(0, 131072)) - 65536);
      default: return val_t'($urandom);
    endcase
  endfunction

  function automatic val_t pick_reg_value();
    case ($urandom_range(0, 7))
      0: return val_t'(VAL_MAX);
      1: return val_t'(VAL_MIN);
      2: return '0;
      3: return val_t'(65536);
      4: return val_t'(-65536);
      default: return val_t'($urandom);
    endcase
  endfunction

  localparam val_t VMAX = val_t'(VAL_MAX);
  localparam val_t VMIN = val_t'(VAL_MIN);

  initial begin
    real a[4];
    real n;
    val_t q[4];
    bit may_idle;

    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity rotation from reset
    send_point('0, '0, '0, 1'b1);
    send_point(VMAX, VMAX, VMAX, 1'b1);
    send_point(VMIN, VMIN, VMIN, 1'b1);
    send_point(VMAX, VMIN, val_t'(1), 1'b1);
    send_point(val_t'(-1), '0, val_t'(-65536), 1'b1);
    send_point(val_t'(65536), val_t'(-1), val_t'(32768), 1'b1);
    drain_pipeline();

    // overflow in both stages
    set_rotation(VMAX, VMAX, VMAX, VMAX);
    send_point(VMAX, VMAX, VMAX, 1'b1);
    send_point(VMIN, VMAX, val_t'(-1), 1'b1);
    send_point(val_t'(1), val_t'(1), val_t'(1), 1'b1);
    drain_pipeline();
    set_rotation(VMIN, VMIN, VMIN, VMIN);
    send_point(VMIN, VMIN, VMIN, 1'b1);
    send_point(VMAX, VMIN, val_t'(3), 1'b1);
    send_point(val_t'(-2), val_t'(40000), val_t'(-70000), 1'b1);
    drain_pipeline();

    // quarter turn about z
    set_rotation(val_t'(46341), '0, '0, val_t'(46341));
    send_point(val_t'(65536), '0, '0, 1'b1);
    send_point('0, val_t'(65536), '0, 1'b1);
    send_point(val_t'(12345), val_t'(-54321), val_t'(100000), 1'b1);
    drain_pipeline();

    // non-unit quaternion
    set_rotation(val_t'(32768), VMIN, val_t'(65536), val_t'(100000));
    send_point(val_t'(1000), val_t'(-1000), val_t'(77), 1'b1);
    send_point(VMAX, '0, VMIN, 1'b1);
    send_point(val_t'(-65536), val_t'(65535), val_t'(-32769), 1'b1);
    drain_pipeline();

    for (int p = 0; p < RANDOM_PHASES + QUIET_PHASES; p++) begin
      case ($urandom_range(0, 2))
        0: begin
          for (int i = 0; i < 4; i++) a[i] = (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0;
          n = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
          if (n < 0.001) begin
            a[0] = 1.0;
            n = 1.0;
          end
          for (int i = 0; i < 4; i++) q[i] = val_t'($rtoi(a[i] / n * 65536.0));
        end
        1: for (int i = 0; i < 4; i++) q[i] = pick_reg_value();
        default: for (int i = 0; i < 4; i++) q[i] = val_t'($urandom);
      endcase
      set_rotation(q[0], q[1], q[2], q[3]);
      may_idle = (p < RANDOM_PHASES) && (p % 4 != 3);
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_point(pick_coord(), pick_coord(), pick_coord(), may_idle);
      drain_pipeline();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_rot.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/qpr_pkg.sv
rtl/qpr_mult.sv
rtl/qpr_sum.sv
rtl/quaternion_point_rotation.sv
rtl/qpr_checker.sv
tb/sv/testbench.sv
